>>> rtl/core/prk_pkg.sv
// Shared types, constants and microprogram for the pendulum RK4 step block.
package prk_pkg;

   localparam int FRAC_BITS      = 24;
   localparam int WORD_BITS      = 32;
   localparam int SIN_ITERATIONS = 24;
   localparam int CORDIC_FRAC    = 30;
   localparam int Z_BITS         = 35;
   localparam int XY_BITS        = 34;
   localparam int REM_STEPS      = 5;
   localparam int CFG_BITS       = 31;
   localparam int PC_BITS        = 6;
   localparam int CNT_BITS       = 5;
   localparam logic [PC_BITS-1:0] PROG_LAST = 6'd59;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic signed [Z_BITS-1:0] PI_W =
      Z_BITS'(((PI_Q60 >> (59 - FRAC_BITS)) + 64'd1) >> 1);
   localparam logic signed [Z_BITS-1:0] TWO_PI_W = Z_BITS'(2 * PI_W);
   localparam logic signed [Z_BITS-1:0] PI_Z =
      Z_BITS'(((PI_Q60 >> 29) + 64'd1) >> 1);
   localparam logic signed [Z_BITS-1:0] HALF_PI_Z =
      Z_BITS'(((PI_Q60 >> 30) + 64'd1) >> 1);
   localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = XY_BITS'(64'h26DD3B6A);
   localparam logic signed [32:0] DIV6_RECIP = 33'h0AAAAAAAB;

   localparam logic [CFG_BITS-1:0] TIME_STEP_RESET = 31'd1666748;
   localparam logic [CFG_BITS-1:0] GRAVITY_RESET   = 31'd167772160;
   localparam logic [CFG_BITS-1:0] DAMPING_RESET   = 31'd33554432;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef enum logic [1:0] {
      CSR_TIME_STEP = 2'd0,
      CSR_GRAVITY   = 2'd1,
      CSR_DAMPING   = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef enum logic {
      ITEM_LOAD = 1'b0,
      ITEM_STEP = 1'b1
   } item_op_type;

   typedef enum logic [2:0] {
      OP_MOV, OP_ADD, OP_NEG, OP_ASR, OP_MUL, OP_DIV6, OP_SIN
   } op_type;

   typedef enum logic [3:0] {
      R_U, R_V, R_H, R_GL, R_D, R_UE, R_VE, R_S, R_P, R_Q, R_T, R_KV, R_KU,
      R_SV, R_SU
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_SIN_ABS, ST_SIN_REM, ST_SIN_WRAP, ST_SIN_FOLD,
      ST_SIN_ITER, ST_SIN_DONE, ST_DONE
   } state_type;

   typedef struct packed {
      op_type  op;
      reg_type dst;
      reg_type src_a;
      reg_type src_b;
   } instr_type;

   // Saturates a wide signed value to the word range; the top bit flags a clip.
   function automatic logic [WORD_BITS:0] sat_word(logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh000000007FFFFFFF;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         sat_word = {1'b1, hi[WORD_BITS-1:0]};
      end else if (v < lo) begin
         sat_word = {1'b1, lo[WORD_BITS-1:0]};
      end else begin
         sat_word = {1'b0, v[WORD_BITS-1:0]};
      end
   endfunction

   function automatic instr_type mk(op_type op, reg_type d, reg_type a, reg_type b);
      mk = '{op: op, dst: d, src_a: a, src_b: b};
   endfunction

   // One derivative evaluation at (UE, VE): KV = h*f(UE,VE), KU = h*VE.
   function automatic instr_type stage_body(logic [2:0] k);
      instr_type ins;
      case (k)
         3'd0: ins = mk(OP_SIN, R_S, R_UE, R_UE);
         3'd1: ins = mk(OP_MUL, R_P, R_GL, R_S);
         3'd2: ins = mk(OP_NEG, R_P, R_P, R_P);
         3'd3: ins = mk(OP_MUL, R_Q, R_D, R_VE);
         3'd4: ins = mk(OP_NEG, R_Q, R_Q, R_Q);
         3'd5: ins = mk(OP_ADD, R_T, R_P, R_Q);
         3'd6: ins = mk(OP_MUL, R_KV, R_H, R_T);
         default: ins = mk(OP_MUL, R_KU, R_H, R_VE);
      endcase
      return ins;
   endfunction

   function automatic instr_type prog_fetch(logic [PC_BITS-1:0] pc);
      instr_type ins;
      ins = mk(OP_MOV, R_T, R_T, R_T);
      if (pc >= 6'd2 && pc <= 6'd9) begin
         ins = stage_body(3'(pc - 6'd2));
      end else if (pc >= 6'd16 && pc <= 6'd23) begin
         ins = stage_body(3'(pc - 6'd16));
      end else if (pc >= 6'd32 && pc <= 6'd39) begin
         ins = stage_body(3'(pc - 6'd32));
      end else if (pc >= 6'd46 && pc <= 6'd53) begin
         ins = stage_body(3'(pc - 6'd46));
      end else begin
         case (pc)
            6'd0:  ins = mk(OP_MOV, R_UE, R_U, R_U);
            6'd1:  ins = mk(OP_MOV, R_VE, R_V, R_V);
            6'd10: ins = mk(OP_MOV, R_SV, R_KV, R_KV);
            6'd11: ins = mk(OP_MOV, R_SU, R_KU, R_KU);
            6'd12: ins = mk(OP_ASR, R_T, R_KV, R_KV);
            6'd13: ins = mk(OP_ADD, R_VE, R_V, R_T);
            6'd14: ins = mk(OP_ASR, R_T, R_KU, R_KU);
            6'd15: ins = mk(OP_ADD, R_UE, R_U, R_T);
            6'd24: ins = mk(OP_ADD, R_T, R_KV, R_KV);
            6'd25: ins = mk(OP_ADD, R_SV, R_SV, R_T);
            6'd26: ins = mk(OP_ADD, R_T, R_KU, R_KU);
            6'd27: ins = mk(OP_ADD, R_SU, R_SU, R_T);
            6'd28: ins = mk(OP_ASR, R_T, R_KV, R_KV);
            6'd29: ins = mk(OP_ADD, R_VE, R_V, R_T);
            6'd30: ins = mk(OP_ASR, R_T, R_KU, R_KU);
            6'd31: ins = mk(OP_ADD, R_UE, R_U, R_T);
            6'd40: ins = mk(OP_ADD, R_T, R_KV, R_KV);
            6'd41: ins = mk(OP_ADD, R_SV, R_SV, R_T);
            6'd42: ins = mk(OP_ADD, R_T, R_KU, R_KU);
            6'd43: ins = mk(OP_ADD, R_SU, R_SU, R_T);
            6'd44: ins = mk(OP_ADD, R_VE, R_V, R_KV);
            6'd45: ins = mk(OP_ADD, R_UE, R_U, R_KU);
            6'd54: ins = mk(OP_ADD, R_SV, R_SV, R_KV);
            6'd55: ins = mk(OP_ADD, R_SU, R_SU, R_KU);
            6'd56: ins = mk(OP_DIV6, R_T, R_SV, R_SV);
            6'd57: ins = mk(OP_ADD, R_V, R_V, R_T);
            6'd58: ins = mk(OP_DIV6, R_T, R_SU, R_SU);
            6'd59: ins = mk(OP_ADD, R_U, R_U, R_T);
            default: ins = mk(OP_MOV, R_T, R_T, R_T);
         endcase
      end
      return ins;
   endfunction

endpackage

>>> rtl/core/prk_req_if.sv
// Request channel interface: valid, ready and one input transaction.
interface prk_req_if
   import prk_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     op;
   word_type coord_in;
   word_type velocity_in;

   modport source(output valid, output op, output coord_in, output velocity_in,
                  input ready);
   modport sink(input valid, input op, input coord_in, input velocity_in,
                output ready);
endinterface

>>> rtl/core/prk_rsp_if.sv
// Response channel interface: valid, ready and one result transaction.
interface prk_rsp_if
   import prk_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type coord_out;
   word_type velocity_out;
   logic     saturated;

   modport source(output valid, output coord_out, output velocity_out,
                  output saturated, input ready);
   modport sink(input valid, input coord_out, input velocity_out,
                input saturated, output ready);
endinterface

>>> rtl/core/pendulum_rk4_step.sv
// Damped pendulum integrator: one fixed-point RK4 step per step transaction.
//
// The block holds angle and angular velocity in signed Q8.24 and answers every
// request transaction with exactly one response transaction carrying the new
// state and a flag that is set when any intermediate or result was clipped.
// A load transaction (op 0) sets the state and answers through the hand-off
// state and output register. A step transaction (op 1) runs a 60-instruction
// microprogram on a single shared datapath (one 33x33 multiplier, a saturating
// adder, shifts), one instruction per cycle, except that each of the four sine
// evaluations runs an issue step, an absolute-value step, a five-step remainder
// by 2*pi, wrap and fold steps, 24 CORDIC rotations and a write-back. A step
// keeps the request side busy through 56 plain instructions, four sines and the
// hand-off state, which waits for a free output register; the CORDIC iterations
// and the sequential microprogram take most of that time. The response sits in
// an output register, so a new request transaction is accepted while the
// previous response still waits. The configuration port (time step, g over
// length, damping, all unsigned Q7.24) is meant to be written while the block
// is idle; index 3 is ignored.
module pendulum_rk4_step
   import prk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   prk_req_if.sink             req_chan,
   prk_rsp_if.source           rsp_chan,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   state_type            state_ff, state_in;
   logic [PC_BITS-1:0]   pc_ff, pc_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 sat_ff, sat_in;

   logic [CFG_BITS-1:0]  h_ff, h_in, gl_ff, gl_in, d_ff, d_in;

   word_type u_ff, u_in, v_ff, v_in, ue_ff, ue_in, ve_ff, ve_in;
   word_type s_ff, s_in, p_ff, p_in, q_ff, q_in, t_ff, t_in;
   word_type kv_ff, kv_in, ku_ff, ku_in, sv_ff, sv_in, su_ff, su_in;

   logic signed [Z_BITS-1:0]  sin_z_ff, sin_z_in;
   logic signed [XY_BITS-1:0] sin_x_ff, sin_x_in, sin_y_ff, sin_y_in;
   logic                      sin_neg_ff, sin_neg_in;

   logic     rsp_valid_ff, rsp_valid_in;
   word_type coord_out_ff, velocity_out_ff;
   logic     sat_out_ff;

   instr_type ins;
   word_type  opa, opb;
   logic      wr_en, load_en, rsp_load;
   word_type  wr_data;
   logic      wr_clip;

   // Shared datapath.
   logic [WORD_BITS-1:0]      div_mag;
   logic signed [32:0]        mul_a, mul_b;
   logic signed [65:0]        mul_p;
   logic [29:0]               div_q;
   word_type                  alu_res;
   logic                      alu_clip;
   logic [WORD_BITS:0]        sat_tmp;

   // Sine sequencer datapath.
   logic signed [Z_BITS-1:0]  abs_z, rem_diff, wrap_r, fold_z, atan_z;
   logic signed [XY_BITS-1:0] dx, dy;
   logic [WORD_BITS:0]        sin_sat;

   logic req_accept;

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign req_accept      = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.coord_out    = coord_out_ff;
   assign rsp_chan.velocity_out = velocity_out_ff;
   assign rsp_chan.saturated    = sat_out_ff;

   assign ins = prog_fetch(pc_ff);

   // Operand read ports over the working registers.
   always_comb begin
      case (ins.src_a)
         R_U:  opa = u_ff;
         R_V:  opa = v_ff;
         R_H:  opa = {1'b0, h_ff};
         R_GL: opa = {1'b0, gl_ff};
         R_D:  opa = {1'b0, d_ff};
         R_UE: opa = ue_ff;
         R_VE: opa = ve_ff;
         R_S:  opa = s_ff;
         R_P:  opa = p_ff;
         R_Q:  opa = q_ff;
         R_T:  opa = t_ff;
         R_KV: opa = kv_ff;
         R_KU: opa = ku_ff;
         R_SV: opa = sv_ff;
         R_SU: opa = su_ff;
         default: opa = t_ff;
      endcase
   end

   always_comb begin
      case (ins.src_b)
         R_U:  opb = u_ff;
         R_V:  opb = v_ff;
         R_H:  opb = {1'b0, h_ff};
         R_GL: opb = {1'b0, gl_ff};
         R_D:  opb = {1'b0, d_ff};
         R_UE: opb = ue_ff;
         R_VE: opb = ve_ff;
         R_S:  opb = s_ff;
         R_P:  opb = p_ff;
         R_Q:  opb = q_ff;
         R_T:  opb = t_ff;
         R_KV: opb = kv_ff;
         R_KU: opb = ku_ff;
         R_SV: opb = sv_ff;
         R_SU: opb = su_ff;
         default: opb = t_ff;
      endcase
   end

   // The multiplier serves both the fixed-point product and the floor
   // division by six, which runs on the bitwise complement of negative values
   // so that one unsigned reciprocal multiply rounds toward minus infinity.
   assign div_mag = opa[WORD_BITS-1] ? ~opa : opa;
   assign mul_a   = (ins.op == OP_DIV6) ? {1'b0, div_mag} : {opa[WORD_BITS-1], opa};
   assign mul_b   = (ins.op == OP_DIV6) ? DIV6_RECIP : {opb[WORD_BITS-1], opb};
   assign mul_p   = mul_a * mul_b;
   assign div_q   = mul_p[63:34];

   always_comb begin
      alu_res  = opa;
      alu_clip = 1'b0;
      sat_tmp  = '0;
      case (ins.op)
         OP_MOV: alu_res = opa;
         OP_ADD: begin
            sat_tmp  = sat_word(64'(opa) + 64'(opb));
            alu_res  = sat_tmp[WORD_BITS-1:0];
            alu_clip = sat_tmp[WORD_BITS];
         end
         OP_NEG: begin
            sat_tmp  = sat_word(-64'(opa));
            alu_res  = sat_tmp[WORD_BITS-1:0];
            alu_clip = sat_tmp[WORD_BITS];
         end
         OP_ASR: alu_res = opa >>> 1;
         OP_MUL: begin
            sat_tmp  = sat_word(64'(mul_p >>> FRAC_BITS));
            alu_res  = sat_tmp[WORD_BITS-1:0];
            alu_clip = sat_tmp[WORD_BITS];
         end
         OP_DIV6: begin
            alu_res = opa[WORD_BITS-1] ? ~{2'b00, div_q} : {2'b00, div_q};
         end
         default: alu_res = opa;
      endcase
   end

   // Sine: truncating remainder by 2*pi one quotient bit per cycle, wrap into
   // [-pi, pi], move to 30 fraction bits, fold into [-pi/2, pi/2], rotate.
   assign abs_z    = opa[WORD_BITS-1] ? -Z_BITS'(opa) : Z_BITS'(opa);
   assign rem_diff = sin_z_ff - (TWO_PI_W <<< cnt_ff);
   assign wrap_r   = sin_neg_ff ? -sin_z_ff : sin_z_ff;
   assign fold_z   = sin_z_ff <<< (CORDIC_FRAC - FRAC_BITS);
   assign atan_z   = signed'({3'b000, ATAN_TABLE[cnt_ff]});
   assign dx       = sin_y_ff >>> cnt_ff;
   assign dy       = sin_x_ff >>> cnt_ff;
   assign sin_sat  = sat_word(64'(sin_y_ff >>> (CORDIC_FRAC - FRAC_BITS)));

   // Sequencer: next state and control.
   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      cnt_in     = cnt_ff;
      sat_in     = sat_ff;
      sin_z_in   = sin_z_ff;
      sin_x_in   = sin_x_ff;
      sin_y_in   = sin_y_ff;
      sin_neg_in = sin_neg_ff;
      wr_en      = 1'b0;
      wr_data    = alu_res;
      wr_clip    = alu_clip;
      load_en    = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sat_in = 1'b0;
               if (req_chan.op == ITEM_LOAD) begin
                  load_en  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  pc_in    = '0;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (ins.op == OP_SIN) begin
               state_in = ST_SIN_ABS;
            end else begin
               wr_en  = 1'b1;
               sat_in = sat_ff | wr_clip;
               if (pc_ff == PROG_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         ST_SIN_ABS: begin
            sin_neg_in = opa[WORD_BITS-1];
            sin_z_in   = abs_z;
            cnt_in     = CNT_BITS'(REM_STEPS - 1);
            state_in   = ST_SIN_REM;
         end
         ST_SIN_REM: begin
            if (!rem_diff[Z_BITS-1]) begin
               sin_z_in = rem_diff;
            end
            if (cnt_ff == '0) begin
               state_in = ST_SIN_WRAP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SIN_WRAP: begin
            if (wrap_r > PI_W) begin
               sin_z_in = wrap_r - TWO_PI_W;
            end else if (wrap_r < -PI_W) begin
               sin_z_in = wrap_r + TWO_PI_W;
            end else begin
               sin_z_in = wrap_r;
            end
            state_in = ST_SIN_FOLD;
         end
         ST_SIN_FOLD: begin
            if (fold_z > HALF_PI_Z) begin
               sin_z_in = PI_Z - fold_z;
            end else if (fold_z < -HALF_PI_Z) begin
               sin_z_in = -PI_Z - fold_z;
            end else begin
               sin_z_in = fold_z;
            end
            sin_x_in = CORDIC_GAIN;
            sin_y_in = '0;
            cnt_in   = '0;
            state_in = ST_SIN_ITER;
         end
         ST_SIN_ITER: begin
            if (!sin_z_ff[Z_BITS-1]) begin
               sin_x_in = sin_x_ff - dx;
               sin_y_in = sin_y_ff + dy;
               sin_z_in = sin_z_ff - atan_z;
            end else begin
               sin_x_in = sin_x_ff + dx;
               sin_y_in = sin_y_ff - dy;
               sin_z_in = sin_z_ff + atan_z;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(SIN_ITERATIONS - 1)) begin
               state_in = ST_SIN_DONE;
            end
         end
         ST_SIN_DONE: begin
            wr_en    = 1'b1;
            wr_data  = sin_sat[WORD_BITS-1:0];
            wr_clip  = sin_sat[WORD_BITS];
            sat_in   = sat_ff | wr_clip;
            pc_in    = pc_ff + 1'b1;
            state_in = ST_EXEC;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Register write-back, state load and configuration writes.
   always_comb begin
      u_in  = u_ff;
      v_in  = v_ff;
      ue_in = ue_ff;
      ve_in = ve_ff;
      s_in  = s_ff;
      p_in  = p_ff;
      q_in  = q_ff;
      t_in  = t_ff;
      kv_in = kv_ff;
      ku_in = ku_ff;
      sv_in = sv_ff;
      su_in = su_ff;
      h_in  = h_ff;
      gl_in = gl_ff;
      d_in  = d_ff;
      if (load_en) begin
         u_in = req_chan.coord_in;
         v_in = req_chan.velocity_in;
      end
      if (wr_en) begin
         case (ins.dst)
            R_U:  u_in  = wr_data;
            R_V:  v_in  = wr_data;
            R_UE: ue_in = wr_data;
            R_VE: ve_in = wr_data;
            R_S:  s_in  = wr_data;
            R_P:  p_in  = wr_data;
            R_Q:  q_in  = wr_data;
            R_T:  t_in  = wr_data;
            R_KV: kv_in = wr_data;
            R_KU: ku_in = wr_data;
            R_SV: sv_in = wr_data;
            R_SU: su_in = wr_data;
            default: ;
         endcase
      end
      if (csr_we) begin
         case (csr_index)
            CSR_TIME_STEP: h_in  = csr_wdata;
            CSR_GRAVITY:   gl_in = csr_wdata;
            CSR_DAMPING:   d_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         h_ff         <= TIME_STEP_RESET;
         gl_ff        <= GRAVITY_RESET;
         d_ff         <= DAMPING_RESET;
         u_ff         <= '0;
         v_ff         <= WORD_BITS'(64'd1 << FRAC_BITS);
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         h_ff         <= h_in;
         gl_ff        <= gl_in;
         d_ff         <= d_in;
         u_ff         <= u_in;
         v_ff         <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      ue_ff      <= ue_in;
      ve_ff      <= ve_in;
      s_ff       <= s_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      t_ff       <= t_in;
      kv_ff      <= kv_in;
      ku_ff      <= ku_in;
      sv_ff      <= sv_in;
      su_ff      <= su_in;
      sin_z_ff   <= sin_z_in;
      sin_x_ff   <= sin_x_in;
      sin_y_ff   <= sin_y_in;
      sin_neg_ff <= sin_neg_in;
      if (rsp_load) begin
         coord_out_ff    <= u_ff;
         velocity_out_ff <= v_ff;
         sat_out_ff      <= sat_ff;
      end
   end

endmodule

>>> rtl/core/prk_checker.sv
// Port-level assertions for the pendulum RK4 step block and their bind.
module prk_checker
   import prk_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     req_op,
   input word_type req_coord_in,
   input word_type req_velocity_in,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input word_type rsp_coord_out,
   input word_type rsp_velocity_out,
   input logic     rsp_saturated
);

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_coord_out) && $stable(rsp_velocity_out)
         && $stable(rsp_saturated))
      else $error("response payload changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction is in progress");

   a_load_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == ITEM_LOAD) && !rsp_valid |=> ##1
         rsp_valid && (rsp_coord_out == $past(req_coord_in, 2))
         && (rsp_velocity_out == $past(req_velocity_in, 2)) && !rsp_saturated)
      else $error("load transaction did not return the loaded state");

endmodule

bind pendulum_rk4_step prk_checker u_prk_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_op           (req_chan.op),
   .req_coord_in     (req_chan.coord_in),
   .req_velocity_in  (req_chan.velocity_in),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_coord_out    (rsp_chan.coord_out),
   .rsp_velocity_out (rsp_chan.velocity_out),
   .rsp_saturated    (rsp_chan.saturated)
);

>>> verif/pendulum_rk4_step_tb.sv
// Self-checking testbench for the pendulum RK4 step block.
module pendulum_rk4_step_tb;
   import prk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 2000000;
   localparam int     TAIL_CYCLES = 250;
   localparam int     MAX_GAP     = 14;

   // One predicted response transaction.
   typedef struct {
      word_type coord;
      word_type velocity;
      logic     saturated;
   } pend_state_type;

   logic clock;
   logic reset;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [CFG_BITS-1:0] csr_wdata;

   prk_req_if req_bus ();
   prk_rsp_if rsp_bus ();

   pendulum_rk4_step uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The predictor keeps its own copy of the pendulum state and the three
   // configuration registers, all in 64-bit signed integers.
   longint model_angle;
   longint model_velocity;
   longint model_cfg [3];
   bit     model_clip;

   pend_state_type pending_states [$];

   int     mismatch_count;
   longint cycle_count;
   bit     send_gaps_on;
   bit     recv_gaps_on;
   int     recv_hold_request;

   // ---------------------------------------------------------------------
   // Fixed-point predictor.
   // ---------------------------------------------------------------------

   // Saturates to the signed 32-bit word range and notes any clip.
   function automatic longint clip_word(longint x);
      if (x > 64'sd2147483647) begin
         model_clip = 1'b1;
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         model_clip = 1'b1;
         return -64'sd2147483648;
      end
      return x;
   endfunction

   // Operands are always word-range values, so the exact product fits in
   // 64 bits and an arithmetic shift gives rounding toward minus infinity.
   function automatic longint fixed_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clip_word(p >>> FRAC_BITS);
   endfunction

   function automatic longint fixed_sin(longint u);
      longint pi_w;
      longint two_pi_w;
      longint pi_z;
      longint half_pi_z;
      longint r;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      pi_w      = longint'(((PI_Q60 >> (59 - FRAC_BITS)) + 64'd1) >> 1);
      two_pi_w  = 2 * pi_w;
      pi_z      = longint'(((PI_Q60 >> 29) + 64'd1) >> 1);
      half_pi_z = longint'(((PI_Q60 >> 30) + 64'd1) >> 1);
      // SystemVerilog remainder truncates toward zero, as the angle
      // reduction requires.
      r = u % two_pi_w;
      if (r > pi_w) begin
         r = r - two_pi_w;
      end else if (r < -pi_w) begin
         r = r + two_pi_w;
      end
      z = r * (64'sd1 << (CORDIC_FRAC - FRAC_BITS));
      // Fold into [-pi/2, pi/2] using sin(x) = sin(+-pi - x).
      if (z > half_pi_z) begin
         z = pi_z - z;
      end else if (z < -half_pi_z) begin
         z = -pi_z - z;
      end
      x = 64'sh26DD3B6A;
      y = 0;
      for (int i = 0; i < SIN_ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TABLE[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TABLE[i]);
         end
      end
      return clip_word(y >>> (CORDIC_FRAC - FRAC_BITS));
   endfunction

   // Acceleration -g/l*sin(u) - d*v with every step saturated.
   function automatic longint accel_of(longint u, longint v);
      longint p;
      longint q;
      p = fixed_mul(model_cfg[CSR_GRAVITY], fixed_sin(u));
      q = fixed_mul(model_cfg[CSR_DAMPING], v);
      return clip_word(clip_word(-p) + clip_word(-q));
   endfunction

   function automatic longint rk4_average(longint k1, longint k2, longint k3, longint k4);
      longint s;
      longint q;
      s = clip_word(k1 + clip_word(k2 + k2));
      s = clip_word(s + clip_word(k3 + k3));
      s = clip_word(s + k4);
      q = s / 6;
      if (s % 6 < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic void rk4_advance();
      longint h;
      longint u;
      longint v;
      longint v2;
      longint v3;
      longint v4;
      longint k1v;
      longint k2v;
      longint k3v;
      longint k4v;
      longint k1u;
      longint k2u;
      longint k3u;
      longint k4u;
      h = model_cfg[CSR_TIME_STEP];
      u = model_angle;
      v = model_velocity;
      k1v = fixed_mul(h, accel_of(u, v));
      k1u = fixed_mul(h, v);
      v2  = clip_word(v + (k1v >>> 1));
      k2v = fixed_mul(h, accel_of(clip_word(u + (k1u >>> 1)), v2));
      k2u = fixed_mul(h, v2);
      v3  = clip_word(v + (k2v >>> 1));
      k3v = fixed_mul(h, accel_of(clip_word(u + (k2u >>> 1)), v3));
      k3u = fixed_mul(h, v3);
      v4  = clip_word(v + k3v);
      k4v = fixed_mul(h, accel_of(clip_word(u + k3u), v4));
      k4u = fixed_mul(h, v4);
      model_velocity = clip_word(v + rk4_average(k1v, k2v, k3v, k4v));
      model_angle    = clip_word(u + rk4_average(k1u, k2u, k3u, k4u));
   endfunction

   // Applies one accepted request transaction and returns the response
   // that the block must produce for it.
   function automatic pend_state_type apply_request(item_op_type op, word_type c, word_type v);
      pend_state_type r;
      model_clip = 1'b0;
      if (op == ITEM_LOAD) begin
         model_angle    = longint'(c);
         model_velocity = longint'(v);
      end else begin
         rk4_advance();
      end
      r.coord     = word_type'(model_angle);
      r.velocity  = word_type'(model_velocity);
      r.saturated = model_clip;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset and the global cycle limit.
   // ---------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A hung handshake would otherwise stall the run forever, so the cycle
   // counter ends it with a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int draw_gap(bit enabled);
      if (!enabled) begin
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   // ---------------------------------------------------------------------
   // Response side: the ready pattern and the checker share one process so
   // that ready gets exactly one assignment per clock edge.
   // ---------------------------------------------------------------------

   initial begin
      int             pause;
      pend_state_type want;
      pause = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_states.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected response: coord %0d velocity %0d sat %0b",
                           rsp_bus.coord_out, rsp_bus.velocity_out, rsp_bus.saturated);
               end
            end else begin
               want = pending_states.pop_front();
               if (rsp_bus.coord_out !== want.coord ||
                   rsp_bus.velocity_out !== want.velocity ||
                   rsp_bus.saturated !== want.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch: coord %0d/%0d vel %0d/%0d sat %0b/%0b (exp/got)",
                              want.coord, rsp_bus.coord_out, want.velocity,
                              rsp_bus.velocity_out, want.saturated, rsp_bus.saturated);
                  end
               end
            end
            pause = draw_gap(recv_gaps_on);
         end
         // A long hold-off request overrides the normal per-transaction gap.
         if (recv_hold_request > 0) begin
            pause = recv_hold_request;
            recv_hold_request = 0;
         end
         if (pause > 0) begin
            rsp_bus.ready <= 1'b0;
            pause--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------

   // Offers one transaction, waits for it to be accepted, records the
   // prediction, and then idles for a random gap. Valid is only lowered
   // when a gap follows, so back-to-back transactions keep it high.
   task automatic send_request(item_op_type op, word_type c, word_type v);
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.coord_in    <= c;
      req_bus.velocity_in <= v;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      pending_states.push_back(apply_request(op, c, v));
      gap = draw_gap(send_gaps_on);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Registers may only change while the block is idle: every response
   // must have come back, and a margin of idle clocks follows.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_states.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers in consecutive cycles and, optionally, a
   // write to the unused index that the block must ignore.
   task automatic write_config(logic [30:0] ts, logic [30:0] gl, logic [30:0] d, bit poke_unused);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_TIME_STEP;
      csr_wdata <= ts;
      @(posedge clock);
      csr_index <= CSR_GRAVITY;
      csr_wdata <= gl;
      @(posedge clock);
      csr_index <= CSR_DAMPING;
      csr_wdata <= d;
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= 31'h7FFFFFFF;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      model_cfg[CSR_TIME_STEP] = longint'(ts);
      model_cfg[CSR_GRAVITY]   = longint'(gl);
      model_cfg[CSR_DAMPING]   = longint'(d);
   endtask

   function automatic word_type draw_word(bit full_range);
      if (full_range) begin
         return word_type'($urandom);
      end
      // Within about +-4.0 in Q8.24, where the pendulum behaves physically.
      return word_type'($urandom_range(0, 32'h07FFFFFF)) - word_type'(32'h04000000);
   endfunction

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Steps straight out of reset use the reset state and reset registers.
   task automatic test_reset_state();
      send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_STEP, '0, '0);
   endtask

   // Loads at the field extremes, each followed by a step that drives the
   // saturating arithmetic, and angles around the reduction boundaries.
   task automatic test_load_extremes();
      send_request(ITEM_LOAD, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_LOAD, 32'sh80000000, 32'sh80000000);
      send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_LOAD, 32'sh7FFFFFFF, 32'sh80000000);
      send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_LOAD, '0, '0);
      send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_LOAD, -32'sd1, -32'sd1);
      send_request(ITEM_STEP, '0, '0);
      // Near +pi and -pi, where the sine folding and wrap kick in.
      send_request(ITEM_LOAD, 32'sh03243F6B, 32'sh00000000);
      send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_LOAD, -32'sh03243F6B, 32'sh01000000);
      send_request(ITEM_STEP, '0, '0);
      // Near 2*pi, and a large angle that needs several wraps.
      send_request(ITEM_LOAD, 32'sh06487ED5, -32'sh01000000);
      send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_LOAD, 32'sh40000000, 32'sh00800000);
      send_request(ITEM_STEP, '0, '0);
   endtask

   // Register extremes: zero step, all-ones registers, and the unused index.
   task automatic test_config_extremes();
      write_config('0, '0, '0, 1'b1);
      send_request(ITEM_LOAD, 32'sh01000000, 32'sh01000000);
      send_request(ITEM_STEP, '0, '0);
      write_config(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0);
      send_request(ITEM_LOAD, 32'sh00400000, -32'sh00400000);
      send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_STEP, '0, '0);
      write_config(TIME_STEP_RESET, GRAVITY_RESET, DAMPING_RESET, 1'b1);
   endtask

   // The receiver holds off for a long stretch while step and load
   // transactions keep arriving, so the output register fills and the
   // block must stall its request side.
   task automatic test_backpressure();
      wait_idle();
      recv_hold_request = 3000;
      send_gaps_on = 1'b0;
      send_request(ITEM_LOAD, 32'sh00800000, 32'sh00200000);
      repeat (6) send_request(ITEM_STEP, '0, '0);
      send_request(ITEM_LOAD, draw_word(1'b1), draw_word(1'b1));
      send_request(ITEM_STEP, '0, '0);
      send_gaps_on = 1'b1;
   endtask

   // Random phases: each phase draws a register setting, then mostly
   // steps with occasional loads of random or physical values.
   task automatic test_random(int total_items);
      int          sent;
      int          phase_len;
      logic [30:0] ts;
      logic [30:0] gl;
      logic [30:0] d;
      sent = 0;
      while (sent < total_items) begin
         if ($urandom_range(0, 4) == 0) begin
            ts = 31'($urandom);
            gl = 31'($urandom);
            d  = 31'($urandom);
         end else begin
            ts = 31'($urandom_range(0, 32'h00400000));
            gl = 31'($urandom_range(0, 32'h10000000));
            d  = 31'($urandom_range(0, 32'h04000000));
         end
         write_config(ts, gl, d, 1'($urandom_range(0, 1)));
         // Some phases run without any idling on either side.
         send_gaps_on = ($urandom_range(0, 3) != 0);
         recv_gaps_on = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(60, 130);
         for (int i = 0; i < phase_len && sent < total_items; i++) begin
            if ($urandom_range(0, 99) < 15) begin
               send_request(ITEM_LOAD, draw_word(1'($urandom_range(0, 1))),
                            draw_word(1'($urandom_range(0, 1))));
            end else begin
               // Payload of a step is ignored, but drive random bits anyway.
               send_request(ITEM_STEP, word_type'($urandom), word_type'($urandom));
            end
            sent++;
         end
      end
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------

   initial begin
      int tail;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_TIME_STEP;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.op          <= ITEM_LOAD;
      req_bus.coord_in    <= '0;
      req_bus.velocity_in <= '0;
      rsp_bus.ready       <= 1'b0;
      cycle_count         <= 0;
      mismatch_count      = 0;
      send_gaps_on        = 1'b1;
      recv_gaps_on        = 1'b1;
      recv_hold_request   = 0;
      // Reset values of the predictor: angle zero, velocity one.
      model_angle              = 0;
      model_velocity           = 64'sd1 << FRAC_BITS;
      model_cfg[CSR_TIME_STEP] = longint'(TIME_STEP_RESET);
      model_cfg[CSR_GRAVITY]   = longint'(GRAVITY_RESET);
      model_cfg[CSR_DAMPING]   = longint'(DAMPING_RESET);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_load_extremes();
      test_config_extremes();
      test_backpressure();
      test_random(950);

      // Drain every outstanding response, then watch a little longer for
      // any stray transaction.
      req_bus.valid <= 1'b0;
      while (pending_states.size() != 0) begin
         @(posedge clock);
      end
      tail = TAIL_CYCLES;
      repeat (tail) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
